// File: sv/nfe_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and sequencer states of the neural field update core.
package nfe_pkg;

  localparam int FIELD_ROWS      = 32;
  localparam int FIELD_COLS      = 32;
  localparam int KERNEL_MAX_ROWS = 9;
  localparam int KERNEL_MAX_COLS = 9;

  localparam int CELL_COUNT = FIELD_ROWS * FIELD_COLS;
  localparam int TAP_COUNT  = KERNEL_MAX_ROWS * KERNEL_MAX_COLS;
  localparam int POS_W      = $clog2(CELL_COUNT);
  localparam int FA_W       = $clog2(2 * CELL_COUNT);
  localparam int KA_W       = $clog2(TAP_COUNT);
  localparam int KDIM_W     = 4;
  localparam int COORD_W    = 12;

  // shared multiplier and accumulator widths
  localparam int MA_W    = 22;
  localparam int MB_W    = 17;
  localparam int P_W     = MA_W + MB_W;
  localparam int ACC_W   = 64;
  localparam int SUM_W   = 36;
  localparam int INNER_W = 39;
  localparam int SPLIT_S = 18;
  localparam int SPLIT_I = 20;
  localparam int Q12     = 12;
  localparam int Q24     = 24;
  localparam int ONE_Q12 = 4096;

  localparam logic [2:0] CFG_KERNEL_ROWS   = 3'd0;
  localparam logic [2:0] CFG_KERNEL_COLS   = 3'd1;
  localparam logic [2:0] CFG_TIME_STEP     = 3'd2;
  localparam logic [2:0] CFG_RESTING_LEVEL = 3'd3;
  localparam logic [2:0] CFG_INPUT_WEIGHT  = 3'd4;
  localparam logic [2:0] CFG_KERNEL_WEIGHT = 3'd5;
  localparam logic [2:0] CFG_WRAP_EDGES    = 3'd6;

  localparam logic MODE_WEIGHT = 1'b0;
  localparam logic MODE_STEP   = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [6:0]         weight_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] stimulus;
  } in_t;

  typedef struct packed {
    logic signed [15:0] activity;
    logic               last_of_frame;
    logic               saturated;
  } out_t;

  // one request to the shared multiply-accumulate unit
  typedef struct packed {
    logic                   valid;
    logic                   clr;
    logic signed [MA_W-1:0] a;
    logic signed [MB_W-1:0] b;
    logic [4:0]             sh;
  } mac_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TAPS, S_UREAD, S_UCAP, S_SUM,
    S_I0, S_I1, S_I2, S_I3, S_I4, S_IW, S_INNER,
    S_T0, S_T1, S_T2, S_T3, S_TW, S_FIN
  } state_t;

endpackage

// File: sv/nfe_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module nfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/nfe_mac.sv
`timescale 1ns / 1ps
// Shared multiplier with registered product and a shifting 64-bit accumulator.
module nfe_mac
  import nfe_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mac_op_t                 op,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [P_W-1:0]   prod;
  logic                    p_vld;
  logic                    p_clr;
  logic [4:0]              p_sh;
  logic signed [ACC_W-1:0] addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= op.valid;
    end
    prod  <= op.a * op.b;
    p_clr <= op.clr;
    p_sh  <= op.sh;
  end

  assign addend = ACC_W'(prod) <<< p_sh;

  always_ff @(posedge clk) begin
    if (p_vld) begin
      acc <= (p_clr ? '0 : acc) + addend;
    end
  end

endmodule

// File: sv/neural_field_euler_update_core.sv
`timescale 1ns / 1ps
// Top level: one Euler step of a 2-D Amari neural field, one cell per request.
//
// Input requests (in_valid / in_stall) carry either a kernel weight (mode 0)
// or the stimulus of the next cell in raster order (mode 1). A weight request
// is taken while the core is idle and gives no result. A cell request walks the
// kernel taps one per cycle through a single shared multiply-accumulate unit,
// then finishes the Euler update on the same unit. in_stall is high for as
// long as a cell is in progress, that is whenever the core is not idle.
// Results (out_valid / out_stall) sit in an output register; a new request is
// taken while one waits, but the next cell stops before its write-back until
// the register is free.
// Configuration writes (cfg_valid / cfg_ready, ready always high) take effect
// at once; issue them only while the core is idle.
// Reset (rst, synchronous) restores the register defaults, the frame position
// and bank select; the old frame reads as zero until the first frame ends, so
// no clearing pass is needed. The kernel store holds nothing until written.
module neural_field_euler_update_core
  import nfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  state_t state, state_next;

  logic [KDIM_W-1:0]  kernel_rows, kernel_cols;
  logic [12:0]        time_step;
  logic signed [15:0] resting_level, input_weight, kernel_weight;
  logic               wrap_edges;

  logic [KDIM_W-1:0]         ti, tj, kr_eff, kc_eff;
  logic signed [15:0]        stim, u;
  logic [POS_W-1:0]          pos;
  logic                      bank_sel, first_frame;
  logic signed [SUM_W-1:0]   sum;
  logic signed [INNER_W-1:0] inner;
  logic                      tap_d, tap_hit_d;

  logic                    in_accept, tap_go, last_tap, fin_go;
  logic signed [COORD_W-1:0] zr, zc;
  logic [COORD_W:0]        mr, mc;
  logic [POS_W-1:0]        tap_cell;
  logic [FA_W-1:0]         fram_raddr, fram_waddr;
  logic [15:0]             fram_rdata, kram_rdata;
  logic [KA_W-1:0]         kram_raddr;
  logic                    kram_we;
  logic signed [15:0]      fval;
  logic [12:0]             clamp;
  mac_op_t                 op, fsm_op;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-Q24-1:0] res_wide;
  logic signed [15:0]      res;
  logic                    res_sat;

  // wrap or pad one coordinate; returns {present, coordinate}
  function automatic logic [COORD_W:0] map_coord(input logic signed [COORD_W-1:0] z,
                                                 input logic signed [COORD_W-1:0] n,
                                                 input logic wrap);
    logic signed [COORD_W-1:0] t;
    logic ok;
    t = z;
    if (wrap && z < 0) begin
      t = z + n;
    end else if (wrap && z >= n) begin
      t = z - n;
    end
    ok = (t >= 0) && (t < n);
    return {ok, t};
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign kr_eff = (kernel_rows > KDIM_W'(KERNEL_MAX_ROWS)) ? KDIM_W'(KERNEL_MAX_ROWS)
                                                            : kernel_rows;
  assign kc_eff = (kernel_cols > KDIM_W'(KERNEL_MAX_COLS)) ? KDIM_W'(KERNEL_MAX_COLS)
                                                            : kernel_cols;
  assign tap_go   = (kr_eff != '0) && (kc_eff != '0);
  assign last_tap = (ti == kr_eff - 1'b1) && (tj == kc_eff - 1'b1);
  assign fin_go   = (state == S_FIN) && (!out_valid || !out_stall);

  // tap coordinates around the current cell
  assign zr = COORD_W'(pos / FIELD_COLS) + COORD_W'(ti) - COORD_W'(kr_eff >> 1);
  assign zc = COORD_W'(pos % FIELD_COLS) + COORD_W'(tj) - COORD_W'(kc_eff >> 1);
  assign mr = map_coord(zr, COORD_W'(FIELD_ROWS), wrap_edges);
  assign mc = map_coord(zc, COORD_W'(FIELD_COLS), wrap_edges);
  assign tap_cell = POS_W'(mr[COORD_W-1:0]) * POS_W'(FIELD_COLS) + POS_W'(mc[COORD_W-1:0]);
  assign kram_raddr = KA_W'(ti) * KA_W'(KERNEL_MAX_COLS) + KA_W'(tj);

  assign fram_raddr = (state == S_TAPS)
                    ? FA_W'(bank_sel) * FA_W'(CELL_COUNT) + FA_W'(tap_cell)
                    : FA_W'(bank_sel) * FA_W'(CELL_COUNT) + FA_W'(pos);
  assign fram_waddr = FA_W'(!bank_sel) * FA_W'(CELL_COUNT) + FA_W'(pos);

  assign kram_we = in_accept && (in_data.mode == MODE_WEIGHT)
                && (in_data.weight_index < 7'(TAP_COUNT));

  nfe_ram #(.WIDTH(16), .DEPTH(2 * CELL_COUNT)) u_field (
    .clk   (clk),
    .we    (fin_go),
    .waddr (fram_waddr),
    .wdata (res),
    .raddr (fram_raddr),
    .rdata (fram_rdata)
  );

  nfe_ram #(.WIDTH(16), .DEPTH(TAP_COUNT)) u_kernel (
    .clk   (clk),
    .we    (kram_we),
    .waddr (in_data.weight_index[KA_W-1:0]),
    .wdata (in_data.weight_value),
    .raddr (kram_raddr),
    .rdata (kram_rdata)
  );

  nfe_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .acc (acc)
  );

  // activity clamped to [0, 1.0] before it enters the tap sum
  assign fval  = $signed(fram_rdata);
  assign clamp = (fval > 16'sd4096) ? 13'(ONE_Q12) : (fval < 0) ? 13'd0 : fval[12:0];

  // final rounding already added; take Q.36 down to Q.12 and saturate
  assign res_wide = acc[ACC_W-1:Q24];
  always_comb begin
    res_sat = 1'b1;
    if (res_wide > 32767) begin
      res = 16'sh7fff;
    end else if (res_wide < -32768) begin
      res = -16'sh8000;
    end else begin
      res     = res_wide[15:0];
      res_sat = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_accept && in_data.mode == MODE_STEP) state_next = S_TAPS;
      S_TAPS:  if (!tap_go || last_tap) state_next = S_UREAD;
      S_UREAD: state_next = S_UCAP;
      S_UCAP:  state_next = S_SUM;
      S_SUM:   state_next = S_I0;
      S_I0:    state_next = S_I1;
      S_I1:    state_next = S_I2;
      S_I2:    state_next = S_I3;
      S_I3:    state_next = S_I4;
      S_I4:    state_next = S_IW;
      S_IW:    state_next = S_INNER;
      S_INNER: state_next = S_T0;
      S_T0:    state_next = S_T1;
      S_T1:    state_next = S_T2;
      S_T2:    state_next = S_T3;
      S_T3:    state_next = S_TW;
      S_TW:    state_next = S_FIN;
      S_FIN:   if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // requests to the shared unit from the sequencer
  always_comb begin
    fsm_op = '0;
    unique case (state)
      S_IDLE: begin
        fsm_op.valid = in_accept && (in_data.mode == MODE_STEP);
        fsm_op.clr   = 1'b1;
      end
      S_I0: begin
        fsm_op.valid = 1'b1;
        fsm_op.clr   = 1'b1;
        fsm_op.a     = MA_W'($signed({1'b0, sum[SPLIT_S-1:0]}));
        fsm_op.b     = MB_W'(kernel_weight);
      end
      S_I1: begin
        fsm_op.valid = 1'b1;
        fsm_op.a     = MA_W'($signed(sum[SUM_W-1:SPLIT_S]));
        fsm_op.b     = MB_W'(kernel_weight);
        fsm_op.sh    = 5'(SPLIT_S);
      end
      S_I2: begin
        fsm_op.valid = 1'b1;
        fsm_op.a     = MA_W'(stim);
        fsm_op.b     = MB_W'(input_weight);
        fsm_op.sh    = 5'(Q12);
      end
      S_I3: begin
        fsm_op.valid = 1'b1;
        fsm_op.a     = MA_W'(resting_level) - MA_W'(u);
        fsm_op.b     = MB_W'(1);
        fsm_op.sh    = 5'(Q24);
      end
      S_I4: begin
        fsm_op.valid = 1'b1;
        fsm_op.a     = MA_W'(1);
        fsm_op.b     = MB_W'(1);
        fsm_op.sh    = 5'(Q12 - 1);
      end
      S_T0: begin
        fsm_op.valid = 1'b1;
        fsm_op.clr   = 1'b1;
        fsm_op.a     = MA_W'($signed({1'b0, inner[SPLIT_I-1:0]}));
        fsm_op.b     = MB_W'($signed({1'b0, time_step}));
      end
      S_T1: begin
        fsm_op.valid = 1'b1;
        fsm_op.a     = MA_W'($signed(inner[INNER_W-1:SPLIT_I]));
        fsm_op.b     = MB_W'($signed({1'b0, time_step}));
        fsm_op.sh    = 5'(SPLIT_I);
      end
      S_T2: begin
        fsm_op.valid = 1'b1;
        fsm_op.a     = MA_W'(u);
        fsm_op.b     = MB_W'(1);
        fsm_op.sh    = 5'(Q24);
      end
      S_T3: begin
        fsm_op.valid = 1'b1;
        fsm_op.a     = MA_W'(1);
        fsm_op.b     = MB_W'(1);
        fsm_op.sh    = 5'(Q24 - 1);
      end
      default: fsm_op = '0;
    endcase
  end

  // taps arrive in the cycle after their reads, while the sequencer is quiet
  always_comb begin
    op = fsm_op;
    if (tap_d) begin
      op.valid = 1'b1;
      op.clr   = 1'b0;
      op.a     = tap_hit_d ? MA_W'($signed({1'b0, clamp})) : '0;
      op.b     = MB_W'($signed(kram_rdata));
      op.sh    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      kernel_rows   <= KDIM_W'(1);
      kernel_cols   <= KDIM_W'(1);
      time_step     <= 13'd410;
      resting_level <= '0;
      input_weight  <= 16'sd4096;
      kernel_weight <= 16'sd4096;
      wrap_edges    <= 1'b0;
      pos           <= '0;
      bank_sel      <= 1'b0;
      first_frame   <= 1'b1;
      tap_d         <= 1'b0;
      out_valid     <= 1'b0;
      ti            <= '0;
      tj            <= '0;
    end else begin
      state <= state_next;
      tap_d <= (state == S_TAPS) && tap_go;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_KERNEL_ROWS:   kernel_rows   <= cfg_data[KDIM_W-1:0];
          CFG_KERNEL_COLS:   kernel_cols   <= cfg_data[KDIM_W-1:0];
          CFG_TIME_STEP:     time_step     <= cfg_data[12:0];
          CFG_RESTING_LEVEL: resting_level <= $signed(cfg_data);
          CFG_INPUT_WEIGHT:  input_weight  <= $signed(cfg_data);
          CFG_KERNEL_WEIGHT: kernel_weight <= $signed(cfg_data);
          CFG_WRAP_EDGES:    wrap_edges    <= cfg_data[0];
          default: ;
        endcase
      end

      if (state == S_IDLE) begin
        ti <= '0;
        tj <= '0;
      end else if (state == S_TAPS && tap_go && !last_tap) begin
        if (tj == kc_eff - 1'b1) begin
          tj <= '0;
          ti <= ti + 1'b1;
        end else begin
          tj <= tj + 1'b1;
        end
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (fin_go) begin
        out_valid <= 1'b1;
        if (pos == POS_W'(CELL_COUNT - 1)) begin
          pos         <= '0;
          bank_sel    <= !bank_sel;
          first_frame <= 1'b0;
        end else begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stim <= in_data.stimulus;
    end
    tap_hit_d <= mr[COORD_W] && mc[COORD_W] && !first_frame;
    if (state == S_UCAP) begin
      u <= first_frame ? 16'sd0 : fval;
    end
    if (state == S_SUM) begin
      sum <= acc[SUM_W-1:0];
    end
    if (state == S_INNER) begin
      inner <= acc[Q12+INNER_W-1:Q12];
    end
    if (fin_go) begin
      out_data.activity      <= res;
      out_data.last_of_frame <= (pos == POS_W'(CELL_COUNT - 1));
      out_data.saturated     <= res_sat;
    end
  end

endmodule
